FILE: sv/tdpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants of the trial division prime test
// Value width, sequencer states and the divider status bundle.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CAND_WIDTH  = 32;
  localparam int unsigned CNT_WIDTH   = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_WIDTH-1:0]   cnt_t;

  localparam value_t VAL_TWO       = value_t'(2);
  localparam value_t FIRST_DIVISOR = value_t'(3);
  localparam value_t DIVISOR_STEP  = value_t'(2);
  localparam cnt_t   LAST_STEP     = cnt_t'(VALUE_WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIV
  } tdpt_state_e;

  typedef struct packed {
    logic   done;
    value_t quot;
    value_t rem;
  } tdpt_div_res_t;

endpackage

FILE: sv/trial_division_prime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Pulse start_i while busy_o is low to hand over one candidate. Two, zero,
// one and even values are settled at once: the result strobe comes in the
// cycle after the beat. Any other value runs odd divisors from 3 upward in
// steps of two through one shared restoring divider, up to sqrt(value) / 2
// divisors. The result is driven for exactly one cycle with valid_o high
// and cannot be held off by the receiver; busy_o drops in the same cycle.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [tdpt_pkg::CAND_WIDTH-1:0]   candidate_i,
  output logic                              valid_o,
  output logic                              is_prime_o
);

  tdpt_pkg::tdpt_state_e   state_q, state_d;
  tdpt_pkg::value_t        val_q, val_d;
  tdpt_pkg::value_t        dvs_q, dvs_d;
  tdpt_pkg::value_t        cand;
  logic                    valid_q, valid_d;
  logic                    prime_q, prime_d;
  logic                    div_start;
  tdpt_pkg::tdpt_div_res_t div_res;

  assign cand = tdpt_pkg::value_t'(candidate_i);

  tdpt_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (val_q),
    .divisor_i  (dvs_q),
    .res_o      (div_res)
  );

  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    dvs_d     = dvs_q;
    valid_d   = 1'b0;
    prime_d   = prime_q;
    div_start = 1'b0;
    case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (start_i) begin
          val_d = cand;
          dvs_d = tdpt_pkg::FIRST_DIVISOR;
          if (cand == tdpt_pkg::VAL_TWO) begin
            valid_d = 1'b1;
            prime_d = 1'b1;
          end else if (cand < tdpt_pkg::VAL_TWO || !cand[0]) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
          end else begin
            state_d = tdpt_pkg::ST_LAUNCH;
          end
        end
      end
      tdpt_pkg::ST_LAUNCH: begin
        div_start = 1'b1;
        state_d   = tdpt_pkg::ST_DIV;
      end
      tdpt_pkg::ST_DIV: begin
        if (div_res.done) begin
          if (dvs_q > div_res.quot) begin
            valid_d = 1'b1;
            prime_d = 1'b1;
            state_d = tdpt_pkg::ST_IDLE;
          end else if (div_res.rem == '0) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
            state_d = tdpt_pkg::ST_IDLE;
          end else begin
            dvs_d   = dvs_q + tdpt_pkg::DIVISOR_STEP;
            state_d = tdpt_pkg::ST_LAUNCH;
          end
        end
      end
      default: begin
        state_d = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdpt_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    dvs_q   <= dvs_d;
    prime_q <= prime_d;
  end

  assign busy_o     = (state_q != tdpt_pkg::ST_IDLE);
  assign valid_o    = valid_q;
  assign is_prime_o = prime_q;

endmodule

FILE: sv/tdpt_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_divider: shared restoring divider
// One quotient bit per cycle; done pulses with quotient and remainder final.
// ----------------------------------------------------------------------------
module tdpt_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tdpt_pkg::value_t      dividend_i,
  input  tdpt_pkg::value_t      divisor_i,
  output tdpt_pkg::tdpt_div_res_t res_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  tdpt_pkg::cnt_t                   cnt_q, cnt_d;
  tdpt_pkg::value_t                 quo_q, quo_d;
  logic [tdpt_pkg::VALUE_WIDTH:0]   rem_q, rem_d;
  logic [tdpt_pkg::VALUE_WIDTH:0]   rem_sh;
  logic [tdpt_pkg::VALUE_WIDTH:0]   div_ext;

  always_comb begin
    rem_sh  = {rem_q[tdpt_pkg::VALUE_WIDTH-1:0], quo_q[tdpt_pkg::VALUE_WIDTH-1]};
    div_ext = {1'b0, divisor_i};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tdpt_pkg::LAST_STEP;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= div_ext) begin
        rem_d = rem_sh - div_ext;
        quo_d = {quo_q[tdpt_pkg::VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[tdpt_pkg::VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - tdpt_pkg::cnt_t'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q[tdpt_pkg::VALUE_WIDTH-1:0];

endmodule

FILE: tb/tb_trial_division_prime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test: self-checking bench of the trial division
// prime test
// Sends candidates through the start/busy handshake and checks each result
// strobe against a verdict computed in the bench. Covers the trivial values,
// odd squares, full-width extremes and the largest 32-bit prime, then a
// random mix of values whose run time stays bounded. Sender idling is random.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_test;

  typedef struct {
    tdpt_pkg::value_t candidate;
    logic             is_prime;
  } verdict_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start_i = 1'b0;
  logic [tdpt_pkg::CAND_WIDTH-1:0] candidate_i = '0;
  logic                            busy_o;
  logic                            valid_o;
  logic                            is_prime_o;

  verdict_t    verdict_q[$];
  verdict_t    oldest_verdict;
  int unsigned err_cnt = 0;

  trial_division_prime_test u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .candidate_i (candidate_i),
    .valid_o     (valid_o),
    .is_prime_o  (is_prime_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic calc_is_prime(tdpt_pkg::value_t v);
    tdpt_pkg::value_t d;
    if (v == tdpt_pkg::value_t'(2)) return 1'b1;
    if (v < tdpt_pkg::value_t'(2) || v[0] == 1'b0) return 1'b0;
    d = tdpt_pkg::value_t'(3);
    while (d <= v / d && (v % d) != '0) d = d + tdpt_pkg::value_t'(2);
    return (d > v / d);
  endfunction

  // random candidate whose trial loop stays short
  function automatic tdpt_pkg::value_t pick_candidate();
    int unsigned w;
    int unsigned p;
    int unsigned q;
    case ($urandom_range(0, 9))
      0, 1, 2: return tdpt_pkg::value_t'($urandom() & 32'hFFFF_FFFE);
      3, 4, 5: begin
        w = $urandom_range(1, 16);
        return tdpt_pkg::value_t'($urandom() >> (32 - w));
      end
      6, 7: begin
        p = 2 * $urandom_range(1, 49) + 1;
        q = $urandom_range(1, 32'hFFFF_FFFF / p);
        return tdpt_pkg::value_t'(p * q);
      end
      default: begin
        w = $urandom_range(17, 20);
        return tdpt_pkg::value_t'(($urandom() >> (32 - w)) | 32'd1);
      end
    endcase
  endfunction

  task automatic send_candidate(tdpt_pkg::value_t v);
    verdict_t item;
    start_i     <= 1'b1;
    candidate_i <= v;
    do @(posedge clk_i); while (busy_o);
    item.candidate = v;
    item.is_prime  = calc_is_prime(v);
    verdict_q.push_back(item);
  endtask

  task automatic idle_burst(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 8));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: expected none, actual is_prime %0b",
                 $time, is_prime_o);
      end else begin
        oldest_verdict = verdict_q.pop_front();
        if (is_prime_o !== oldest_verdict.is_prime) begin
          err_cnt++;
          $display("%0t: is_prime of %0d: expected %0b, actual %0b", $time,
                   oldest_verdict.candidate, oldest_verdict.is_prime, is_prime_o);
        end
      end
    end
  end

  task automatic test_trivial_values();
    send_candidate(tdpt_pkg::value_t'(0));
    send_candidate(tdpt_pkg::value_t'(1));
    send_candidate(tdpt_pkg::value_t'(2));
    maybe_idle();
    send_candidate(tdpt_pkg::value_t'(4));
    send_candidate(tdpt_pkg::value_t'(32'hFFFF_FFFE));
    send_candidate(tdpt_pkg::value_t'(32'h8000_0000));
    wait_drained();
  endtask

  task automatic test_small_odd();
    send_candidate(tdpt_pkg::value_t'(3));
    send_candidate(tdpt_pkg::value_t'(5));
    send_candidate(tdpt_pkg::value_t'(7));
    send_candidate(tdpt_pkg::value_t'(9));
    idle_burst(3);
    send_candidate(tdpt_pkg::value_t'(15));
    send_candidate(tdpt_pkg::value_t'(25));
    send_candidate(tdpt_pkg::value_t'(49));
    send_candidate(tdpt_pkg::value_t'(97));
    send_candidate(tdpt_pkg::value_t'(121));
    // square of a prime: loop stops exactly at d*d == value
    send_candidate(tdpt_pkg::value_t'(63001));
    send_candidate(tdpt_pkg::value_t'(65537));
    wait_drained();
  endtask

  task automatic test_full_width();
    send_candidate(tdpt_pkg::value_t'(32'hFFFF_FFFF));
    send_candidate(tdpt_pkg::value_t'(32'h8000_0001));
    send_candidate(tdpt_pkg::value_t'(32'h7FFF_FFFF) & tdpt_pkg::value_t'(32'h5555_5555));
    wait_drained();
  endtask

  task automatic test_largest_prime();
    send_candidate(tdpt_pkg::value_t'(32'd4294967291));
    send_candidate(tdpt_pkg::value_t'(2));
    wait_drained();
  endtask

  task automatic test_random_mix(int unsigned n_items, int unsigned calm_tail);
    for (int unsigned i = 0; i < n_items; i++) begin
      send_candidate(pick_candidate());
      if (i % 25 == 24) wait_drained();
      else if (i < n_items - calm_tail) maybe_idle();
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_trivial_values();
    test_small_odd();
    test_full_width();
    test_largest_prime();
    test_random_mix(80, 20);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) $display("tb_trial_division_prime_test: clean");
    else $display("tb_trial_division_prime_test: errors");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_trial_division_prime_test: errors");
    $finish;
  end

endmodule

FILE: sim.f
sv/tdpt_pkg.sv
sv/tdpt_divider.sv
sv/trial_division_prime_test.sv
tb/tb_trial_division_prime_test.sv
